// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LPH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LPH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// shared types, codes and constants of the linear probe hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lph_pkg;

    localparam int DEFAULT_SLOTS = 1024;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 11;
    localparam int KIND_W   = 3;
    localparam int IN_W     = 136;
    localparam int OUT_W    = 80;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;

    localparam logic [KIND_W-1:0] K_INSERT   = 3'd0;
    localparam logic [KIND_W-1:0] K_LOOKUP   = 3'd1;
    localparam logic [KIND_W-1:0] K_CLEAR    = 3'd2;
    localparam logic [KIND_W-1:0] K_RESERVED = 3'd3;
    localparam logic [KIND_W-1:0] K_MISS     = 3'd4;

    localparam logic [KEY_W-1:0] EMPTY_KEY = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIX_C1 = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_C2 = 64'hBF58_476D_1CE4_E5B9;
    localparam int MIX_SHIFT1 = 31;
    localparam int MIX_SHIFT2 = 29;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } job_t;

endpackage

// ===== rtl/core/lph_front.sv =====
// ----------------------------------------------------------------------------
// lph_front
// accepts commands, classifies them and computes the home slot of a key
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lph_front #(
    parameter int SLOTS = lph_pkg::DEFAULT_SLOTS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lph_pkg::IN_W-1:0]  s_tdata,   // command, key, value
    output logic                      push,
    output lph_pkg::job_t             push_job,
    output logic [$clog2(SLOTS)-1:0]  push_home,
    input  logic                      q_full
);

    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   round_reg, round_next;
    logic [63:0]            x_reg, x_next;
    logic [63:0]            acc_reg, acc_next;
    logic [SLOT_W-1:0]      rem_reg, rem_next;
    lph_pkg::job_t          job_reg, job_next;

    logic [lph_pkg::CMD_W-1:0] in_cmd;
    logic [lph_pkg::KEY_W-1:0] in_key;
    logic [lph_pkg::VAL_W-1:0] in_val;
    logic [lph_pkg::KIND_W-1:0] in_kind;
    logic [63:0] mul_c;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod, term, sum, mix;
    logic              accept;

    assign in_cmd = s_tdata[lph_pkg::CMD_W-1:0];
    assign in_key = s_tdata[lph_pkg::CMD_W +: lph_pkg::KEY_W];
    assign in_val = s_tdata[lph_pkg::CMD_W + lph_pkg::KEY_W +: lph_pkg::VAL_W];

    assign s_tready = (state_reg == F_IDLE) && en;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        case (in_cmd)
            lph_pkg::CMD_INSERT:
            begin
                in_kind = (in_key == lph_pkg::EMPTY_KEY) ? lph_pkg::K_RESERVED
                                                         : lph_pkg::K_INSERT;
            end
            lph_pkg::CMD_LOOKUP:
            begin
                in_kind = (in_key == lph_pkg::EMPTY_KEY) ? lph_pkg::K_MISS
                                                         : lph_pkg::K_LOOKUP;
            end
            lph_pkg::CMD_CLEAR: in_kind = lph_pkg::K_CLEAR;
            default:            in_kind = lph_pkg::K_MISS;
        endcase
    end

    // shared 32x32 multiplier, three partial products per 64-bit multiply
    assign mul_c = round_reg ? lph_pkg::MIX_C2 : lph_pkg::MIX_C1;
    assign mul_a = (phase_reg == 2'd1) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (phase_reg == 2'd2) ? mul_c[63:32] : mul_c[31:0];
    assign prod  = mul_a * mul_b;
    assign term  = (phase_reg == 2'd0) ? prod : {prod[31:0], 32'd0};
    assign sum   = ((phase_reg == 2'd0) ? 64'd0 : acc_reg) + term;
    assign mix   = round_reg ? (sum ^ (sum >> lph_pkg::MIX_SHIFT2))
                             : (sum ^ (sum >> lph_pkg::MIX_SHIFT1));

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        round_next = round_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        job_next   = job_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    job_next.kind  = in_kind;
                    job_next.key   = in_key;
                    job_next.value = in_val;
                    x_next         = in_key;
                    phase_next     = 2'd0;
                    round_next     = 1'b0;
                    rem_next       = '0;
                    if (in_kind == lph_pkg::K_INSERT || in_kind == lph_pkg::K_LOOKUP)
                    begin
                        state_next = F_HASH;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_HASH:
            begin
                acc_next = sum;
                if (phase_reg == 2'd2)
                begin
                    phase_next = 2'd0;
                    x_next     = mix;
                    if (round_reg)
                    begin
                        // home slot is the low bits of the hash
                        rem_next   = mix[SLOT_W-1:0];
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        round_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign push_job  = job_reg;
    assign push_home = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            phase_reg <= 2'd0;
            round_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        job_reg <= job_next;
    end

endmodule

// ===== rtl/core/lph_queue.sv =====
// ----------------------------------------------------------------------------
// lph_queue
// short fifo of classified jobs between the front and the probe engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lph_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] data
);

    localparam int DEPTH = lph_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] buf_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign valid   = (cnt_reg != '0);
    assign data    = buf_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `LPH_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, cnt_reg <= CNT_FULL)
    `LPH_ASSERT_NXT(a_pop_drains, clk, rst_n, do_pop && !do_push, cnt_reg == $past(cnt_reg) - 1'b1)

endmodule

// ===== rtl/core/lph_back.sv =====
// ----------------------------------------------------------------------------
// lph_back
// probe engine: slot memory, linear probing, clearing sweep, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lph_back #(
    parameter int SLOTS = lph_pkg::DEFAULT_SLOTS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    output logic                      ready,
    input  logic                      q_valid,
    input  lph_pkg::job_t             q_job,
    input  logic [$clog2(SLOTS)-1:0]  q_home,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lph_pkg::OUT_W-1:0] m_tdata    // status, found_value, entries
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ROW_W  = lph_pkg::KEY_W + lph_pkg::VAL_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W:0]   CNT_MAX   = (SLOT_W+1)'(SLOTS);

    localparam logic [2:0] B_INIT  = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_PROBE = 3'd2;
    localparam logic [2:0] B_CLEAR = 3'd3;
    localparam logic [2:0] B_CDONE = 3'd4;

    logic [ROW_W-1:0] mem [SLOTS];
    logic [ROW_W-1:0] rd_q;

    logic [2:0]        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W:0]   count_reg, count_next;
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0] n_reg, n_next;
    logic [SLOT_W-1:0] addr_reg, addr_next;
    lph_pkg::job_t     job_reg, job_next;
    logic [lph_pkg::STATUS_W-1:0] out_status_reg, emit_status;
    logic [lph_pkg::VAL_W-1:0]    out_found_reg, emit_found;
    logic [lph_pkg::ENTRY_W-1:0]  out_entries_reg;

    logic              rd_en, wr_en, emit, out_free;
    logic [SLOT_W-1:0] rd_addr, wr_addr;
    logic [ROW_W-1:0]  wr_data;
    logic [lph_pkg::KEY_W-1:0] rd_key;
    logic              is_empty, is_match;

    assign ready    = (state_reg != B_INIT);
    assign out_free = !out_valid_reg || m_tready;
    assign rd_key   = rd_q[lph_pkg::KEY_W-1:0];
    assign is_empty = (rd_key == lph_pkg::EMPTY_KEY);
    assign is_match = (rd_key == job_reg.key);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        n_next        = n_reg;
        addr_next     = addr_reg;
        job_next      = job_reg;
        rd_en         = 1'b0;
        rd_addr       = addr_reg;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = {job_reg.value, job_reg.key};
        q_pop         = 1'b0;
        emit          = 1'b0;
        emit_status   = lph_pkg::ST_MISS;
        emit_found    = '0;
        case (state_reg)
            B_INIT, B_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = {{lph_pkg::VAL_W{1'b0}}, lph_pkg::EMPTY_KEY};
                if (clr_addr_reg == LAST_SLOT)
                begin
                    clr_addr_next = '0;
                    state_next    = (state_reg == B_INIT) ? B_IDLE : B_CDONE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            B_CDONE:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = lph_pkg::ST_CLEARED;
                    count_next  = '0;
                    state_next  = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_job.kind)
                        lph_pkg::K_INSERT, lph_pkg::K_LOOKUP:
                        begin
                            q_pop      = 1'b1;
                            job_next   = q_job;
                            rd_en      = 1'b1;
                            rd_addr    = q_home;
                            addr_next  = q_home;
                            n_next     = '0;
                            state_next = B_PROBE;
                        end
                        lph_pkg::K_CLEAR:
                        begin
                            q_pop      = 1'b1;
                            state_next = B_CLEAR;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                q_pop       = 1'b1;
                                emit        = 1'b1;
                                emit_status = (q_job.kind == lph_pkg::K_RESERVED)
                                              ? lph_pkg::ST_RESERVED : lph_pkg::ST_MISS;
                            end
                        end
                    endcase
                end
            end
            B_PROBE:
            begin
                if (is_empty || is_match || n_reg == LAST_SLOT)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = B_IDLE;
                        if (job_reg.kind == lph_pkg::K_INSERT)
                        begin
                            if (is_match)
                            begin
                                emit_status = lph_pkg::ST_PRESENT;
                            end
                            else if (is_empty)
                            begin
                                emit_status = lph_pkg::ST_STORED;
                                wr_en       = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                            else
                            begin
                                emit_status = lph_pkg::ST_FULL;
                            end
                        end
                        else if (is_match)
                        begin
                            emit_status = lph_pkg::ST_HIT;
                            emit_found  = rd_q[ROW_W-1:lph_pkg::KEY_W];
                        end
                    end
                end
                else
                begin
                    addr_next = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = addr_next;
                    n_next    = n_reg + 1'b1;
                end
            end
            default: state_next = B_IDLE;
        endcase
        out_valid_next = emit || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            clr_addr_reg  <= clr_addr_next;
            n_reg         <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        job_reg  <= job_next;
        if (emit)
        begin
            out_status_reg  <= emit_status;
            out_found_reg   <= emit_found;
            out_entries_reg <= lph_pkg::ENTRY_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lph_pkg::OUT_W - lph_pkg::ENTRY_W - lph_pkg::VAL_W
                        - lph_pkg::STATUS_W){1'b0}},
                       out_entries_reg, out_found_reg, out_status_reg};

    `LPH_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_MAX)
    `LPH_ASSERT_IMP(a_store_into_empty, clk, rst_n, wr_en && state_reg == B_PROBE, is_empty)
    `LPH_ASSERT_NXT(a_store_counts, clk, rst_n, emit && emit_status == lph_pkg::ST_STORED, count_reg == $past(count_reg) + 1'b1)
    `LPH_ASSERT_IMP(a_emit_slot_free, clk, rst_n, emit, out_free)

endmodule

// ===== rtl/core/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing hash table of 64-bit keys and values with linear probing
// ----------------------------------------------------------------------------
// input beats on s_*: command (insert, lookup, clear), key, value
// output beats on m_*: one per input beat, in order: status, found_value,
// entries (occupied slots after the command)
// front: classifies the command and hashes the key on one shared 32x32
// multiplier; the home slot is the low bits of the hash, so SLOTS must be a
// power of two, which the block itself does not enforce
// back: reads one slot per cycle from the slot memory until it finds the key,
// an empty slot, or has probed all SLOTS slots
// a 2-entry job queue lets the front hash the next key while the back probes
// insert/lookup: the front bounds the beat rate while probe runs stay at
// 7 slots or fewer, else the back's probe runs do
// reserved key or unused command: no hash in the front, no probe in the back
// clear: the back sweeps all SLOTS slots empty before it gives its result
// after reset the back sweeps all SLOTS slots empty with s_tready low; when
// m_tready is low the result holds in the output register and the back
// waits to emit the next, while the front and queue keep taking beats until full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_hash_table #(
    parameter int SLOTS = lph_pkg::DEFAULT_SLOTS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lph_pkg::IN_W-1:0]  s_tdata,   // command[1:0], key[65:2], value[129:66]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lph_pkg::OUT_W-1:0] m_tdata    // status[2:0], found_value[66:3], entries[77:67]
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int JOB_W  = $bits(lph_pkg::job_t) + SLOT_W;

    logic              back_ready;
    logic              push, q_full, q_valid, q_pop;
    lph_pkg::job_t     push_job, q_job;
    logic [SLOT_W-1:0] push_home, q_home;
    logic [JOB_W-1:0]  q_data;

    lph_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_ready),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_job  (push_job),
        .push_home (push_home),
        .q_full    (q_full)
    );

    lph_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_home, push_job}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    assign q_job  = q_data[$bits(lph_pkg::job_t)-1:0];
    assign q_home = q_data[JOB_W-1:$bits(lph_pkg::job_t)];

    lph_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ready    (back_ready),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_home   (q_home),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
